>>> rtl/scf_pkg.sv
// ============================================================================
// scf_pkg: shared definitions for segment credit flow control
// Opcodes, register indexes, reset values, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package scf_pkg;

    // Bytes of a write offer that are honored.
    localparam int BYTE_CNT_W = 32;
    localparam logic [31:0] BYTE_MASK = 32'((64'd1 << BYTE_CNT_W) - 64'd1);

    localparam int OPCODE_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int USED_W      = 17;
    localparam int RUNT_W      = 16;

    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FLUSH_P = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH_A = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ACK_OK  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLOSE   = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEG_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUF_LIMIT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SEG_SIZE_RST  = 16'd1400;
    localparam logic [CFG_DATA_W-1:0] BUF_LIMIT_RST = 16'd1024;

    localparam logic [USED_W-1:0] USED_MAX = 17'h1FFFF;

    // The divider retires two quotient bits per cycle over a 32-bit dividend.
    localparam int DIV_STEPS = 32 / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FREE,
        ST_DIV,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic free;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic write_go;
    } t_stat;

endpackage

>>> rtl/segment_credit_flow_control.sv
// ============================================================================
// segment_credit_flow_control: watermark-acknowledged transmit credit
// Tracks used segments, the partial-segment remainder and the pending
// watermark of a segmented transmit buffer, one command at a time.
// ============================================================================
// Usage:
// Commands enter on the input channel (i_in_valid / o_in_ready) with an
// opcode and a byte count; every command yields exactly one result beat on
// the output channel (o_out_valid / i_out_ready). Segment size and buffer
// limit are written through the configuration channel (i_cfg_valid /
// o_cfg_ready, index 0 and 1; other indexes are ignored) between commands.
// A write passes from acceptance through the 16x16 free-space product, the
// fit check and the radix-4 divider that splits the granted bytes plus the
// partial-segment remainder into segments and a new remainder. Flushes,
// acknowledgements, closes and refused writes go on to commit without the
// divider. The result register decouples the sides: a new command is
// accepted while the previous result still waits, and only the commit of
// the next result stalls on a busy receiver. Reset clears the state, sets
// segment size to 1400 and buffer limit to 1024, and drops any result.
// ============================================================================
module segment_credit_flow_control import scf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [31:0]            i_num_bytes,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [31:0]            o_bytes_accepted,
    output logic                   o_watermark_request,
    output logic                   o_credit_released,
    output logic                   o_pending_now,
    output logic [USED_W-1:0]      o_segments_used,
    output logic [RUNT_W-1:0]      o_partial_bytes,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    scf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    scf_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_opcode            (i_opcode),
        .i_num_bytes         (i_num_bytes),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_bytes_accepted    (o_bytes_accepted),
        .o_watermark_request (o_watermark_request),
        .o_credit_released   (o_credit_released),
        .o_pending_now       (o_pending_now),
        .o_segments_used     (o_segments_used),
        .o_partial_bytes     (o_partial_bytes)
    );

    // Releasing credit always retires the pending watermark.
    a_release_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_credit_released) |-> !o_pending_now)
        else $error("credit released while a watermark is still pending");

endmodule

>>> rtl/scf_ctrl.sv
// ============================================================================
// scf_ctrl: sequencer for segment credit flow control
// Steps an item through multiply, free-space, divide and commit, skipping the
// phases that it does not need, and owns the input, output and config handshakes.
// ============================================================================
module scf_ctrl import scf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic                i_out_ready,
    input  t_stat               i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_cfg_ready,
    output t_cmd                o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid;
    logic                 w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_WRITE) ? ST_MUL : ST_COMMIT;
                end
            end
            ST_MUL: begin
                n_state = i_stat.write_go ? ST_FREE : ST_COMMIT;
            end
            ST_FREE: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cfg_ready     = (r_state == ST_IDLE);
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul       = (r_state == ST_MUL);
        o_cmd.free      = (r_state == ST_FREE);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.commit    = (r_state == ST_COMMIT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Only a write that has room and a nonzero segment size reaches the divider.
    a_div_only_when_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> i_stat.write_go)
        else $error("divider running for an item that does not need it");

    // A result beat is only raised out of the commit phase.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_COMMIT))
        else $error("result beat raised outside commit");

endmodule

>>> rtl/scf_dp.sv
// ============================================================================
// scf_dp: datapath for segment credit flow control
// Holds the configuration and flow-control state, computes free space,
// divides the granted bytes into segments and a remainder, and keeps the
// result register.
// ============================================================================
module scf_dp import scf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [31:0]            i_num_bytes,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [31:0]            o_bytes_accepted,
    output logic                   o_watermark_request,
    output logic                   o_credit_released,
    output logic                   o_pending_now,
    output logic [USED_W-1:0]      o_segments_used,
    output logic [RUNT_W-1:0]      o_partial_bytes
);

    logic [CFG_DATA_W-1:0] r_seg_size, r_buf_limit;
    logic [USED_W-1:0]     r_used, n_used;
    logic [RUNT_W-1:0]     r_runt, n_runt;
    logic                  r_pending, n_pending;

    logic [OPCODE_W-1:0]   r_op;
    logic [31:0]           r_offer;
    logic [31:0]           r_product;
    logic [31:0]           r_grant;
    logic                  r_fits;
    logic [31:0]           r_dvd;
    logic [RUNT_W-1:0]     r_rem;

    logic [USED_W-1:0]     w_half;
    logic                  w_go;
    logic [15:0]           w_room;
    logic [31:0]           w_product;
    logic [31:0]           w_free;
    logic                  w_fits;
    logic [16:0]           w_t1, w_t2;
    logic                  w_q1, w_q2;
    logic [RUNT_W-1:0]     w_r1, w_r2;
    logic [USED_W:0]       w_used_sum;
    logic                  w_wm, w_rel, w_check;
    logic [31:0]           w_grant;

    assign w_half = {2'b0, r_buf_limit[15:1]};
    assign w_go   = (r_op == OP_WRITE) && (r_seg_size != '0)
                    && (r_used < {1'b0, r_buf_limit});
    assign o_stat.write_go = w_go;

    // Free whole segments, valid only while the write has room.
    assign w_room    = 16'({1'b0, r_buf_limit} - r_used);
    assign w_product = 32'(r_seg_size) * 32'(w_room);

    assign w_free = (r_product > {16'b0, r_runt}) ? r_product - {16'b0, r_runt} : '0;
    assign w_fits = (r_offer <= w_free);

    // Two restoring-division steps per cycle; the remainder stays below the divisor.
    always_comb begin
        w_t1 = {r_rem, r_dvd[31]};
        w_q1 = (w_t1 >= {1'b0, r_seg_size});
        w_r1 = w_q1 ? 16'(w_t1 - {1'b0, r_seg_size}) : w_t1[15:0];
        w_t2 = {w_r1, r_dvd[30]};
        w_q2 = (w_t2 >= {1'b0, r_seg_size});
        w_r2 = w_q2 ? 16'(w_t2 - {1'b0, r_seg_size}) : w_t2[15:0];
    end

    // The quotient never exceeds 16 bits, so the low 17 bits carry it whole.
    assign w_used_sum = {1'b0, r_used} + {1'b0, r_dvd[USED_W-1:0]};

    always_comb begin
        n_used    = r_used;
        n_runt    = r_runt;
        n_pending = r_pending;
        w_wm      = 1'b0;
        w_rel     = 1'b0;
        w_check   = 1'b0;
        w_grant   = '0;
        unique case (r_op)
            OP_WRITE: begin
                if (w_go) begin
                    w_grant = r_grant;
                    w_check = 1'b1;
                    if (r_fits) begin
                        n_used = w_used_sum[USED_W] ? USED_MAX : w_used_sum[USED_W-1:0];
                        n_runt = r_rem;
                    end else begin
                        n_used = {1'b0, r_buf_limit};
                    end
                end
            end
            OP_FLUSH_P, OP_FLUSH_A: begin
                if ((r_op == OP_FLUSH_A) && !r_pending) begin
                    w_wm = 1'b1;
                end
                if (r_runt != '0) begin
                    n_used  = (r_used == USED_MAX) ? r_used : r_used + 1'b1;
                    n_runt  = '0;
                    w_check = 1'b1;
                end
            end
            OP_ACK_OK: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_used    = (r_used > w_half) ? r_used - w_half : '0;
                    w_rel     = 1'b1;
                end
            end
            OP_CLOSE: begin
                n_used    = '0;
                n_runt    = '0;
                n_pending = 1'b0;
            end
            default: ;
        endcase
        if (w_check && !r_pending && (n_used >= w_half)) begin
            w_wm      = 1'b1;
            n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size  <= SEG_SIZE_RST;
            r_buf_limit <= BUF_LIMIT_RST;
            r_used      <= '0;
            r_runt      <= '0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_SEG_SIZE)) begin
                r_seg_size <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_BUF_LIMIT)) begin
                r_buf_limit <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_used    <= n_used;
                r_runt    <= n_runt;
                r_pending <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_offer <= i_num_bytes & BYTE_MASK;
        end
        if (i_cmd.mul) begin
            r_product <= w_product;
        end
        if (i_cmd.free) begin
            r_grant <= (w_fits ? r_offer : w_free) & BYTE_MASK;
            r_fits  <= w_fits;
            r_dvd   <= w_fits ? r_offer + {16'b0, r_runt} : '0;
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[29:0], w_q1, w_q2};
            r_rem <= w_r2;
        end
        if (i_cmd.commit) begin
            o_bytes_accepted    <= w_grant;
            o_watermark_request <= w_wm;
            o_credit_released   <= w_rel;
            o_pending_now       <= n_pending;
            o_segments_used     <= n_used;
            o_partial_bytes     <= n_runt;
        end
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < r_seg_size))
        else $error("division remainder reached the segment size");

    a_refused_write_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op == OP_WRITE) && !w_go)
        |=> ((r_used == $past(r_used)) && (r_runt == $past(r_runt))
             && (r_pending == $past(r_pending))))
        else $error("a refused write changed the flow-control state");

endmodule
